>>> rtl/bsr_pkg.sv
// bisection root finder package: sequencer step codes, control word type,
// the microcode program and the sign threshold of the polynomial
// no dependencies
package bsr_pkg;

   localparam int unsigned TOL_WIDTH = 31;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd1049;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_TEST,
      STEP_MID,
      STEP_UPD,
      STEP_OUT
   } step_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_REQ,
      HOLD_RSP
   } hold_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_ALWAYS,
      BR_DONE
   } branch_type;

   typedef struct packed {
      hold_type   hold;
      logic       ld_in;
      logic       ld_mid;
      logic       upd;
      logic       ld_out;
      branch_type br;
      step_type   target;
   } ctrl_type;

   // control store: one word per step
   function automatic ctrl_type microcode(step_type step);
      ctrl_type cw;
      cw = '{hold: HOLD_NONE, ld_in: 1'b0, ld_mid: 1'b0, upd: 1'b0, ld_out: 1'b0,
             br: BR_ALWAYS, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            cw.hold  = HOLD_REQ;
            cw.ld_in = 1'b1;
            cw.br    = BR_NEXT;
         end
         STEP_TEST: begin
            cw.br     = BR_DONE;
            cw.target = STEP_OUT;
         end
         STEP_MID: begin
            cw.ld_mid = 1'b1;
            cw.br     = BR_NEXT;
         end
         STEP_UPD: begin
            cw.upd    = 1'b1;
            cw.br     = BR_ALWAYS;
            cw.target = STEP_TEST;
         end
         STEP_OUT: begin
            cw.hold   = HOLD_RSP;
            cw.ld_out = 1'b1;
            cw.br     = BR_ALWAYS;
            cw.target = STEP_IDLE;
         end
         default: begin
            cw.br     = BR_ALWAYS;
            cw.target = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

   // largest raw x >= 0 with x^5 + x^2 * 2^(3f) < 5 * 2^(5f); the polynomial
   // rises for x > 0 and has no rational root, so x > threshold means f > 0
   function automatic logic [63:0] root_threshold(int unsigned frac);
      logic [255:0] x;
      logic [255:0] sq;
      logic [255:0] lhs;
      logic [255:0] rhs;
      logic [63:0]  t;
      logic [63:0]  c;
      int           b;
      rhs = 256'd5 << (5 * frac);
      t   = 64'd0;
      for (b = int'(frac); b >= 0; b--) begin
         c   = t | (64'd1 << b);
         x   = 256'(c);
         sq  = x * x;
         lhs = sq * sq * x + (sq << (3 * frac));
         if (lhs < rhs) begin
            t = c;
         end
      end
      return t;
   endfunction

endpackage

>>> rtl/bisection_root_finder.sv
// bisection root finder top level: microcoded sequencer and its datapath
// depends on bsr_pkg (step codes, control store, sign threshold)
//
// usage: an interval (req_lower_end, req_upper_end) is taken as one transfer on the
// req_ channel; one result (rsp_root) leaves on the rsp_ channel. the tolerance
// register is written through the csr_ channel, which is always ready; the user
// must write it only while the block is idle, as the block itself does not enforce this.
// timing: req_ready is high only in the idle step. after the transfer each
// bisection iteration runs three steps (test, midpoint, update); a last test
// step ends the loop, then one output step follows. the number of iterations n
// is about log2((upper - lower) / (2 * tolerance)). the iteration loop of the
// program sets the rate; the sign of f is a single compare against a threshold
// fixed at elaboration, so each iteration needs no multiplier.
// the result sits in an output register; if the receiver stalls, the block
// finishes the next item and waits in its output step until that register is
// free.
// reset: synchronous, active high; clears the sequencer to idle, drops
// rsp_valid and sets the tolerance to 1049 (about 0.001).
module bisection_root_finder #(
   parameter int unsigned WORD_WIDTH    = 32,
   parameter int unsigned FRACTION_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [WORD_WIDTH-1:0]  req_lower_end,
   input  logic signed [WORD_WIDTH-1:0]  req_upper_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [WORD_WIDTH-1:0]  rsp_root,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bsr_pkg::TOL_WIDTH-1:0] csr_data
);
   import bsr_pkg::*;

   localparam int unsigned TW = FRACTION_BITS + 2;
   localparam int unsigned EW = (WORD_WIDTH - 1 > TW) ? WORD_WIDTH - 1 : TW;
   localparam int unsigned DW = (WORD_WIDTH + 1 > TOL_WIDTH + 1) ? WORD_WIDTH + 1
                                                                  : TOL_WIDTH + 1;
   localparam logic [EW-1:0] THRESH = EW'(root_threshold(FRACTION_BITS));

   step_type              pc_ff, pc_in;
   logic [WORD_WIDTH-1:0] lo_ff, lo_in;
   logic [WORD_WIDTH-1:0] hi_ff, hi_in;
   logic [WORD_WIDTH-1:0] mid_ff, mid_in;
   logic [WORD_WIDTH-1:0] root_ff, root_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TOL_WIDTH-1:0]  tol_ff, tol_in;

   ctrl_type              cw;
   logic                  stall;
   logic                  taken;
   logic                  done;
   logic                  hi_gt_lo;
   logic [WORD_WIDTH:0]   diff;
   logic [WORD_WIDTH:0]   req_sum;
   logic [WORD_WIDTH:0]   cur_sum;
   logic [TOL_WIDTH:0]    limit;
   logic                  lo_pos;
   logic                  mid_pos;

   // f > 0 exactly when the raw argument is above the threshold
   function automatic logic f_positive(logic [WORD_WIDTH-1:0] x);
      return !x[WORD_WIDTH-1] && (EW'(x[WORD_WIDTH-2:0]) > THRESH);
   endfunction

   always_comb begin
      cw = microcode(pc_ff);

      req_sum  = {req_lower_end[WORD_WIDTH-1], req_lower_end}
               + {req_upper_end[WORD_WIDTH-1], req_upper_end};
      cur_sum  = {lo_ff[WORD_WIDTH-1], lo_ff} + {hi_ff[WORD_WIDTH-1], hi_ff};
      hi_gt_lo = $signed(hi_ff) > $signed(lo_ff);
      diff     = {hi_ff[WORD_WIDTH-1], hi_ff} - {lo_ff[WORD_WIDTH-1], lo_ff};
      // zero tolerance behaves as one
      limit    = {((tol_ff == '0) ? TOL_WIDTH'(1) : tol_ff), 1'b0};
      done     = !hi_gt_lo || !(DW'(diff) > DW'(limit));
      lo_pos   = f_positive(lo_ff);
      mid_pos  = f_positive(mid_ff);

      stall = ((cw.hold == HOLD_REQ) && !req_valid)
           || ((cw.hold == HOLD_RSP) && rsp_valid_ff && !rsp_ready);
      taken = (cw.br == BR_ALWAYS) || ((cw.br == BR_DONE) && done);

      pc_in        = pc_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tol_in       = csr_valid ? csr_data : tol_ff;

      if (!stall) begin
         if (taken) begin
            pc_in = cw.target;
         end else begin
            pc_in = step_type'(3'(pc_ff) + 3'd1);
         end
         if (cw.ld_in) begin
            lo_in  = req_lower_end;
            hi_in  = req_upper_end;
            mid_in = req_sum[WORD_WIDTH:1];
         end
         if (cw.ld_mid) begin
            mid_in = cur_sum[WORD_WIDTH:1];
         end
         if (cw.upd) begin
            // same sign on both sides: root lies above the midpoint
            if (lo_pos == mid_pos) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
         end
         if (cw.ld_out) begin
            root_in      = mid_ff;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= TOL_RESET;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_ff       <= tol_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      root_ff <= root_in;
   end

   assign req_ready = (pc_ff == STEP_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_root  = root_ff;
   assign csr_ready = 1'b1;

endmodule

>>> tb/sv/bisection_root_finder_checker.sv
`timescale 1ns / 100ps
// bisection root finder checker: watches the req_, rsp_ and csr_ channels, predicts each root
// by exact bisection on x^5 + x^2 - 5 and compares it with the rsp_ transfers
// depends on bsr_pkg (tolerance width and reset value)
module bisection_root_finder_checker #(
   parameter int unsigned WORD_WIDTH    = 32,
   parameter int unsigned FRACTION_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [WORD_WIDTH-1:0]  req_lower_end,
   input  logic signed [WORD_WIDTH-1:0]  req_upper_end,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [WORD_WIDTH-1:0]  rsp_root,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [bsr_pkg::TOL_WIDTH-1:0] csr_data,
   output int                            fail_count,
   output int                            pending_roots
);

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] lower;
      logic signed [WORD_WIDTH-1:0] upper;
      logic signed [WORD_WIDTH-1:0] root;
   } bracket_root_type;

   bracket_root_type              expected_roots[$];
   logic [bsr_pkg::TOL_WIDTH-1:0] tolerance;

   // sign of f at raw fixed-point x, exact: x^5 + x^2 * 2^(3f) against 5 * 2^(5f)
   function automatic int poly_sign(longint x);
      logic [255:0] xw;
      logic [255:0] sq;
      logic [255:0] lhs;
      logic [255:0] rhs;
      if (x <= 0) return -1;
      xw  = 256'(x);
      sq  = xw * xw;
      lhs = sq * sq * xw + (sq << (3 * FRACTION_BITS));
      rhs = 256'd5 << (5 * FRACTION_BITS);
      if (lhs > rhs) return 1;
      if (lhs < rhs) return -1;
      return 0;
   endfunction

   function automatic logic signed [WORD_WIDTH-1:0] bisect_root(
      logic signed [WORD_WIDTH-1:0]  lower,
      logic signed [WORD_WIDTH-1:0]  upper,
      logic [bsr_pkg::TOL_WIDTH-1:0] tol
   );
      longint lo;
      longint hi;
      longint limit;
      longint mid;
      int     s_lo;
      int     s_mid;
      lo    = lower;
      hi    = upper;
      limit = tol;
      limit = (tol == '0) ? 2 : 2 * limit;
      mid   = (lo + hi) >>> 1;
      if (hi > lo) begin
         while (hi - lo > limit) begin
            mid   = lo + ((hi - lo) >>> 1);
            s_lo  = poly_sign(lo);
            s_mid = poly_sign(mid);
            if (s_lo != 0 && s_lo == s_mid) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
      end
      return mid[WORD_WIDTH-1:0];
   endfunction

   initial begin
      fail_count    = 0;
      pending_roots = 0;
      tolerance     = bsr_pkg::TOL_RESET;
   end

   always @(posedge clock) begin
      bracket_root_type item;
      bracket_root_type head;
      if (reset) begin
         tolerance = bsr_pkg::TOL_RESET;
         expected_roots.delete();
      end else begin
         if (req_valid && req_ready) begin
            item.lower = req_lower_end;
            item.upper = req_upper_end;
            item.root  = bisect_root(req_lower_end, req_upper_end, tolerance);
            expected_roots.push_back(item);
         end
         if (csr_valid && csr_ready) begin
            tolerance = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_roots.size() == 0) begin
               $display("%0t: unexpected root transfer %0d, expected none", $time, rsp_root);
               fail_count++;
            end else begin
               head = expected_roots.pop_front();
               if (rsp_root !== head.root) begin
                  $display("%0t: root for [%0d, %0d]: expected %0d, actual %0d",
                           $time, head.lower, head.upper, head.root, rsp_root);
                  fail_count++;
               end
            end
         end
      end
      pending_roots = expected_roots.size();
   end

endmodule

>>> tb/sv/bisection_root_finder_tb.sv
`timescale 1ns / 100ps
// bisection root finder testbench top: clock, reset, interval and tolerance stimulus,
// random stalls on both channels and the verdict
// depends on bisection_root_finder, bisection_root_finder_checker and bsr_pkg
module bisection_root_finder_tb;

   localparam int unsigned CYCLE_LIMIT     = 900_000;
   localparam int          ITEMS_PER_PHASE = 80;
   localparam int          TOL_PHASES      = 7;
   localparam longint      ROOT_NEAR       = 1337000;  // about 1.2751 in Q11.20
   localparam longint      WORD_MIN        = -(longint'(1) << 31);
   localparam longint      WORD_MAX        = (longint'(1) << 31) - 1;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [31:0]            req_lower_end;
   logic signed [31:0]            req_upper_end;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [31:0]            rsp_root;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [bsr_pkg::TOL_WIDTH-1:0] csr_data;

   int                            fail_count;
   int                            pending_roots;
   logic [bsr_pkg::TOL_WIDTH-1:0] cur_tol;
   bit                            flood_hold;
   int unsigned                   cycle_count;

   bisection_root_finder u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_lower_end (req_lower_end),
      .req_upper_end (req_upper_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_root      (rsp_root),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   bisection_root_finder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_lower_end (req_lower_end),
      .req_upper_end (req_upper_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_root      (rsp_root),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_roots (pending_roots)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL bisection_root_finder");
      $finish;
   end

   // mostly short idles, a few long ones
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic longint clamp_word(longint v);
      if (v < WORD_MIN) return WORD_MIN;
      if (v > WORD_MAX) return WORD_MAX;
      return v;
   endfunction

   // receiver: ready stretches, random stalls, one long hold-off on request
   initial begin
      int run;
      int stall;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (flood_hold) begin
            flood_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (500) @(negedge clock);
         end
         run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         stall = idle_length();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // starts and returns at a falling edge; leaves req_valid high after the transfer
   task automatic send_interval(input longint lower, input longint upper);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_lower_end <= 32'(clamp_word(lower));
      req_upper_end <= 32'(clamp_word(upper));
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // only once every root has come back, so the block sits idle
   task automatic write_tolerance(input logic [bsr_pkg::TOL_WIDTH-1:0] value);
      req_valid <= 1'b0;
      while (pending_roots != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_tol = value;
   endtask

   task automatic send_random_interval();
      longint mask;
      longint lo;
      longint hi;
      longint width;
      int     pick;
      mask = (longint'(1) << $urandom_range(0, 31)) - 1;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         // bracket around the positive root
         lo = ROOT_NEAR - (longint'($urandom) & mask);
         hi = ROOT_NEAR + (longint'($urandom) & mask);
      end else if (pick < 70) begin
         lo = longint'(signed'(32'($urandom)));
         hi = longint'(signed'(32'($urandom)));
         if (lo > hi) begin
            width = lo;
            lo    = hi;
            hi    = width;
         end
      end else if (pick < 80) begin
         // width right around the stop threshold
         width = longint'(cur_tol);
         width = 2 * width + $urandom_range(0, 4) - 2;
         lo    = longint'(signed'(32'($urandom)));
         hi    = lo + width;
      end else if (pick < 90) begin
         // upper not above lower
         lo = longint'(signed'(32'($urandom)));
         hi = lo - (longint'($urandom) & mask);
      end else begin
         // around zero, where f is negative on the left
         lo = -(longint'($urandom) & mask);
         hi = lo + (longint'($urandom) & mask);
      end
      send_interval(lo, hi);
   endtask

   initial begin
      logic [bsr_pkg::TOL_WIDTH-1:0] tol;
      int                            phase;
      int                            n;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_lower_end = '0;
      req_upper_end = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      cur_tol       = bsr_pkg::TOL_RESET;
      flood_hold    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed intervals at the reset tolerance
      send_interval(WORD_MIN, WORD_MAX);
      send_interval(WORD_MAX, WORD_MIN);
      send_interval(0, 0);
      send_interval(WORD_MIN, WORD_MIN);
      send_interval(WORD_MAX, WORD_MAX);
      send_interval(0, 4 << 20);
      send_interval(1 << 20, 2 << 20);
      send_interval(2 << 20, 8 << 20);
      send_interval(-(8 << 20), -(1 << 20));
      send_interval(-(1 << 20), 1 << 20);
      send_interval(100, 100 + 2 * 1049);
      send_interval(100, 101 + 2 * 1049);
      send_interval(-1, 0);
      send_interval(0, 1);
      send_interval(-3, 0);
      send_interval(WORD_MIN, 0);
      send_interval(0, WORD_MAX);
      send_interval(ROOT_NEAR - 5000, ROOT_NEAR + 5000);
      send_interval(5, 3);
      send_interval(-3, WORD_MIN);
      send_interval(longint'(signed'(32'haaaaaaaa)), longint'(signed'(32'h55555555)));
      send_interval(longint'(signed'(32'h80000001)), longint'(signed'(32'h7ffffffe)));

      for (phase = 0; phase < TOL_PHASES; phase++) begin
         case (phase)
            0:       tol = 31'd1;
            1:       tol = 31'h7fffffff;
            2:       tol = 31'd0;
            6:       tol = bsr_pkg::TOL_RESET;
            default: tol = 31'($urandom_range(1, 32'd1 << $urandom_range(0, 30)));
         endcase
         write_tolerance(tol);
         if (phase == 0) flood_hold = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random_interval();
         end
      end

      req_valid <= 1'b0;
      while (pending_roots != 0) @(negedge clock);
      repeat (120) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS bisection_root_finder");
      end else begin
         $display("FAIL bisection_root_finder");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/bsr_pkg.sv
rtl/bisection_root_finder.sv
tb/sv/bisection_root_finder_checker.sv
tb/sv/bisection_root_finder_tb.sv
